### rtl/per_channel_contrast_stretch_core_macros.svh
// Assertion macros for the contrast stretch RTL.
`ifndef PER_CHANNEL_CONTRAST_STRETCH_CORE_MACROS_SVH
`define PER_CHANNEL_CONTRAST_STRETCH_CORE_MACROS_SVH

// The condition implies the consequence in the same cycle.
`define PCCS_ASSERT_IMPLY(label, clk, rst_n, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// The condition implies the consequence in the next cycle.
`define PCCS_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

### rtl/pccs_pkg.sv
// Types, constants and codes shared by the contrast stretch modules.
`default_nettype none

package pccs_pkg;

  localparam int unsigned COMPONENT_BITS_DEF = 8;
  localparam int unsigned LEVEL_BITS         = 8;
  localparam int unsigned SPAN_BITS          = LEVEL_BITS + 1;
  localparam int unsigned MUL_STEPS          = SPAN_BITS;
  localparam int unsigned QUO_BITS           = LEVEL_BITS;
  localparam int unsigned STEP_BITS          = $clog2(MUL_STEPS);
  localparam int unsigned NUM_CHAN           = 3;
  localparam int unsigned CMD_BITS           = 2;
  localparam int unsigned CFG_IDX_BITS       = 2;

  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_MEASURE = 2'd1,
    CMD_MAP     = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_OUT_MIN = 2'd0,
    REG_OUT_MAX = 2'd1
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic first;
    logic prep;
    logic div;
  } lane_ctrl_t;

endpackage

`default_nettype wire

### rtl/per_channel_contrast_stretch_core.sv
// Top level of the per-channel min/max contrast stretch core.
//
// The core stretches RGB pixels in two passes. A clear word sets the running
// minima to full scale and the maxima to zero, measure words widen each
// channel's minimum and maximum, and map words return one result word with
// every channel computed as trunc((out_min*d + (out_max-out_min)*(v-min)) / d),
// d = max - min, clamped to 0..255. A channel whose maximum equals its minimum
// returns out_min and sets its flat_mask bit. Clear, measure and unknown
// command words are taken without stalling and return nothing. A map word
// keeps the input stalled until its result is handed over: each channel
// lane forms the numerator bit-serially over nine shift-add steps, checks
// signs and overflow in a separate step, then produces its eight quotient
// bits one per cycle with a restoring divider, and a final step hands the
// result to the output register once that register is free. The three channel
// lanes run side by side. The output register lets a finished word wait
// while the core accepts the next input. The out_min and out_max registers
// are written through the configuration port, which is always ready; write
// them only while the core is idle.
`default_nettype none
`include "per_channel_contrast_stretch_core_macros.svh"

module per_channel_contrast_stretch_core #(
  parameter int unsigned COMPONENT_BITS = pccs_pkg::COMPONENT_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Input words.
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [pccs_pkg::CMD_BITS-1:0]         cmd_i,
  input  logic [COMPONENT_BITS-1:0]             red_i,
  input  logic [COMPONENT_BITS-1:0]             green_i,
  input  logic [COMPONENT_BITS-1:0]             blue_i,
  // Result words.
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [pccs_pkg::LEVEL_BITS-1:0]       red_out_o,
  output logic [pccs_pkg::LEVEL_BITS-1:0]       green_out_o,
  output logic [pccs_pkg::LEVEL_BITS-1:0]       blue_out_o,
  output logic [pccs_pkg::NUM_CHAN-1:0]         flat_mask_o,
  // Configuration writes.
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [pccs_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [pccs_pkg::LEVEL_BITS-1:0]       cfg_data_i
);
  import pccs_pkg::*;

  state_e                      state_q, state_d;
  logic [STEP_BITS-1:0]        cnt_q, cnt_d;
  lane_ctrl_t                  ctrl;
  logic                        load_out;
  logic                        in_accept;

  logic [LEVEL_BITS-1:0]       out_min_q, out_max_q;
  logic signed [SPAN_BITS-1:0] span;

  // Running statistics, one entry per channel (red, green, blue).
  logic [COMPONENT_BITS-1:0]   lo_q [NUM_CHAN];
  logic [COMPONENT_BITS-1:0]   hi_q [NUM_CHAN];
  logic [COMPONENT_BITS-1:0]   comp [NUM_CHAN];

  logic [LEVEL_BITS-1:0]       lane_level [NUM_CHAN];
  logic [NUM_CHAN-1:0]         lane_flat;

  logic                        out_valid_q;
  logic [LEVEL_BITS-1:0]       out_level_q [NUM_CHAN];
  logic [NUM_CHAN-1:0]         out_flat_q;

  assign comp[0] = red_i;
  assign comp[1] = green_i;
  assign comp[2] = blue_i;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // The span may be negative when out_min is above out_max.
  assign span = $signed({1'b0, out_max_q}) - $signed({1'b0, out_min_q});

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_min_q <= '0;
      out_max_q <= LEVEL_MAX;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_e'(cfg_index_i))
        REG_OUT_MIN: out_min_q <= cfg_data_i;
        REG_OUT_MAX: out_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Statistics are updated in the cycle the clear or measure word is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        lo_q[c] <= '1;
        hi_q[c] <= '0;
      end
    end else if (in_accept) begin
      unique case (cmd_e'(cmd_i))
        CMD_CLEAR: begin
          for (int c = 0; c < NUM_CHAN; c++) begin
            lo_q[c] <= '1;
            hi_q[c] <= '0;
          end
        end
        CMD_MEASURE: begin
          for (int c = 0; c < NUM_CHAN; c++) begin
            if (comp[c] < lo_q[c]) lo_q[c] <= comp[c];
            if (comp[c] > hi_q[c]) hi_q[c] <= comp[c];
          end
        end
        default: ;
      endcase
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and lane strobes. A map word loads the lanes as it is taken.
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ctrl     = '0;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && (cmd_i == CMD_MAP)) begin
          ctrl.load = 1'b1;
          state_d   = ST_MUL;
          cnt_d     = '0;
        end
      end
      ST_MUL: begin
        ctrl.mul   = 1'b1;
        ctrl.first = (cnt_q == '0);
        if (cnt_q == STEP_BITS'(MUL_STEPS - 1)) begin
          state_d = ST_PREP;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_PREP: begin
        ctrl.prep = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        ctrl.div = 1'b1;
        if (cnt_q == STEP_BITS'(QUO_BITS - 1)) begin
          state_d = ST_DONE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DONE: begin
        // Hand over only once the output register is free.
        if (!(out_valid_q && out_stall_i)) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
    pccs_lane #(
      .COMPONENT_BITS(COMPONENT_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .omin_i (out_min_q),
      .span_i (span),
      .comp_i (comp[c]),
      .lo_i   (lo_q[c]),
      .hi_i   (hi_q[c]),
      .level_o(lane_level[c]),
      .flat_o (lane_flat[c])
    );
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= load_out || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        out_level_q[c] <= lane_level[c];
      end
      out_flat_q <= lane_flat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_level_q[0];
  assign green_out_o = out_level_q[1];
  assign blue_out_o  = out_level_q[2];
  assign flat_mask_o = out_flat_q;

  `PCCS_ASSERT_NEXT(a_map_starts, clk_i, rst_ni, in_accept && (cmd_i == CMD_MAP), (state_q == ST_MUL) && (cnt_q == '0), "map word did not start the multiply")
  `PCCS_ASSERT_NEXT(a_stats_one_cycle, clk_i, rst_ni, in_accept && (cmd_i != CMD_MAP), state_q == ST_IDLE, "non-map word left the core busy")
  `PCCS_ASSERT_IMPLY(a_out_from_done, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == ST_DONE, "result appeared without a finished divide")

endmodule

`default_nettype wire

### rtl/pccs_lane.sv
// One color channel: bit-serial multiply, sign and range check, bit-serial divide.
`default_nettype none

module pccs_lane #(
  parameter int unsigned COMPONENT_BITS = pccs_pkg::COMPONENT_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  pccs_pkg::lane_ctrl_t                   ctrl_i,
  input  logic [pccs_pkg::LEVEL_BITS-1:0]        omin_i,
  input  logic signed [pccs_pkg::SPAN_BITS-1:0]  span_i,
  input  logic [COMPONENT_BITS-1:0]              comp_i,
  input  logic [COMPONENT_BITS-1:0]              lo_i,
  input  logic [COMPONENT_BITS-1:0]              hi_i,
  output logic [pccs_pkg::LEVEL_BITS-1:0]        level_o,
  output logic                                   flat_o
);
  import pccs_pkg::*;

  localparam int unsigned DW = COMPONENT_BITS + 1;
  localparam int unsigned NW = COMPONENT_BITS + SPAN_BITS + 1;
  localparam int unsigned MW = NW - 1;

  logic signed [DW-1:0]          d_q, e_q;
  logic [MUL_STEPS-1:0]          om_sr_q, sp_sr_q;
  logic signed [NW-1:0]          acc_q, acc_d;
  logic [QUO_BITS-1:0]           nlo_q, quo_q;
  logic [COMPONENT_BITS-1:0]     rem_q, dmag_q;
  logic                          neg_q, ovf_q, flat_q;

  logic signed [NW-1:0]          d_ext, e_ext, pd, pe;
  logic [NW-1:0]                 nmag_full;
  logic [MW-1:0]                 nmag;
  logic [DW-1:0]                 dmag_full;
  logic [COMPONENT_BITS-1:0]     dmag;
  logic                          ovf;
  logic [COMPONENT_BITS:0]       r2, dmag_ext, rdiff;
  logic                          ge;

  always_comb begin
    d_ext = {{(NW-DW){d_q[DW-1]}}, d_q};
    e_ext = {{(NW-DW){e_q[DW-1]}}, e_q};
    pd    = om_sr_q[MUL_STEPS-1] ? d_ext : '0;
    // The top coefficient bit of the span carries negative weight.
    pe    = sp_sr_q[MUL_STEPS-1] ? (ctrl_i.first ? -e_ext : e_ext) : '0;
    acc_d = (acc_q <<< 1) + pd + pe;

    nmag_full = acc_q[NW-1] ? NW'(-acc_q) : NW'(acc_q);
    nmag      = nmag_full[MW-1:0];
    dmag_full = d_q[DW-1] ? DW'(-d_q) : DW'(d_q);
    dmag      = dmag_full[COMPONENT_BITS-1:0];
    ovf       = nmag[MW-1:QUO_BITS] >= {1'b0, dmag};

    r2       = {rem_q, nlo_q[QUO_BITS-1]};
    dmag_ext = {1'b0, dmag_q};
    ge       = r2 >= dmag_ext;
    rdiff    = r2 - dmag_ext;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      d_q     <= $signed({1'b0, hi_i}) - $signed({1'b0, lo_i});
      e_q     <= $signed({1'b0, comp_i}) - $signed({1'b0, lo_i});
      om_sr_q <= {1'b0, omin_i};
      sp_sr_q <= span_i;
      acc_q   <= '0;
    end else if (ctrl_i.mul) begin
      acc_q   <= acc_d;
      om_sr_q <= {om_sr_q[MUL_STEPS-2:0], 1'b0};
      sp_sr_q <= {sp_sr_q[MUL_STEPS-2:0], 1'b0};
    end
    if (ctrl_i.prep) begin
      rem_q  <= nmag[QUO_BITS +: COMPONENT_BITS];
      nlo_q  <= nmag[QUO_BITS-1:0];
      dmag_q <= dmag;
      quo_q  <= '0;
    end else if (ctrl_i.div) begin
      rem_q <= ge ? rdiff[COMPONENT_BITS-1:0] : r2[COMPONENT_BITS-1:0];
      nlo_q <= {nlo_q[QUO_BITS-2:0], 1'b0};
      quo_q <= {quo_q[QUO_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q  <= 1'b0;
      ovf_q  <= 1'b0;
      flat_q <= 1'b0;
    end else if (ctrl_i.prep) begin
      neg_q  <= acc_q[NW-1] ^ d_q[DW-1];
      ovf_q  <= ovf;
      flat_q <= (d_q == '0);
    end
  end

  always_comb begin
    priority if (flat_q) begin
      level_o = omin_i;
    end else if (neg_q) begin
      level_o = '0;
    end else if (ovf_q) begin
      level_o = LEVEL_MAX;
    end else begin
      level_o = quo_q;
    end
  end

  assign flat_o = flat_q;

endmodule

`default_nettype wire

### dv/contrast_stretch_checker.sv
// Checker that predicts and compares the result words of the contrast stretch core.
`timescale 1ns / 1ps

module contrast_stretch_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [pccs_pkg::CMD_BITS-1:0]     cmd_i,
  input  logic [pccs_pkg::LEVEL_BITS-1:0]   red_i,
  input  logic [pccs_pkg::LEVEL_BITS-1:0]   green_i,
  input  logic [pccs_pkg::LEVEL_BITS-1:0]   blue_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic [pccs_pkg::LEVEL_BITS-1:0]   red_out_i,
  input  logic [pccs_pkg::LEVEL_BITS-1:0]   green_out_i,
  input  logic [pccs_pkg::LEVEL_BITS-1:0]   blue_out_i,
  input  logic [pccs_pkg::NUM_CHAN-1:0]     flat_mask_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [pccs_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [pccs_pkg::LEVEL_BITS-1:0]   cfg_data_i,
  output int                                mismatch_count_o,
  output int                                pending_o
);
  import pccs_pkg::*;

  localparam int OUT_CEIL    = 255;
  localparam int SHOW_LIMIT  = 10;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] red;
    logic [LEVEL_BITS-1:0] green;
    logic [LEVEL_BITS-1:0] blue;
    logic [NUM_CHAN-1:0]   flat;
  } stretched_px_t;

  stretched_px_t         stretched_q[$];
  logic [LEVEL_BITS-1:0] level_min;
  logic [LEVEL_BITS-1:0] level_max;
  logic [LEVEL_BITS-1:0] chan_lo [NUM_CHAN];
  logic [LEVEL_BITS-1:0] chan_hi [NUM_CHAN];

  function automatic void clear_stats();
    for (int c = 0; c < NUM_CHAN; c++) begin
      chan_lo[c] = LEVEL_MAX;
      chan_hi[c] = '0;
    end
  endfunction

  // Exact integer stretch of one channel, truncated toward zero and clamped.
  function automatic logic [LEVEL_BITS-1:0] stretch_level(input logic [LEVEL_BITS-1:0] v,
                                                          input logic [LEVEL_BITS-1:0] lo,
                                                          input logic [LEVEL_BITS-1:0] hi,
                                                          output logic flat);
    int span;
    int ramp;
    int q;
    span = int'(hi) - int'(lo);
    flat = (span == 0);
    if (span == 0) return level_min;
    ramp = int'(level_max) - int'(level_min);
    q = (int'(level_min) * span + ramp * (int'(v) - int'(lo))) / span;
    if (q < 0) q = 0;
    else if (q > OUT_CEIL) q = OUT_CEIL;
    return q[LEVEL_BITS-1:0];
  endfunction

  function automatic stretched_px_t predict_map(input logic [LEVEL_BITS-1:0] px [NUM_CHAN]);
    stretched_px_t         res;
    logic [LEVEL_BITS-1:0] lvl [NUM_CHAN];
    for (int c = 0; c < NUM_CHAN; c++) begin
      lvl[c] = stretch_level(px[c], chan_lo[c], chan_hi[c], res.flat[c]);
    end
    res.red   = lvl[0];
    res.green = lvl[1];
    res.blue  = lvl[2];
    return res;
  endfunction

  function automatic void report(input string what, input stretched_px_t want,
                                 input stretched_px_t got);
    mismatch_count_o++;
    if (mismatch_count_o <= SHOW_LIMIT) begin
      $display("%0t: %s: expected r=%0d g=%0d b=%0d flat=%b, got r=%0d g=%0d b=%0d flat=%b",
               $realtime, what, want.red, want.green, want.blue, want.flat,
               got.red, got.green, got.blue, got.flat);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    stretched_px_t         got;
    stretched_px_t         want;
    logic [LEVEL_BITS-1:0] px [NUM_CHAN];
    if (!rst_ni) begin
      stretched_q.delete();
      level_min = '0;
      level_max = LEVEL_MAX;
      clear_stats();
      pending_o = 0;
    end else begin
      // A result leaving at this edge always belongs to an earlier word.
      if (out_valid_i && !out_stall_i) begin
        got = '{red_out_i, green_out_i, blue_out_i, flat_mask_i};
        if (stretched_q.size() == 0) begin
          report("result word with nothing expected", '0, got);
        end else begin
          want = stretched_q.pop_front();
          if (got !== want) report("result word mismatch", want, got);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        px = '{red_i, green_i, blue_i};
        case (cmd_i)
          CMD_CLEAR: clear_stats();
          CMD_MEASURE: begin
            for (int c = 0; c < NUM_CHAN; c++) begin
              if (px[c] < chan_lo[c]) chan_lo[c] = px[c];
              if (px[c] > chan_hi[c]) chan_hi[c] = px[c];
            end
          end
          CMD_MAP: stretched_q.push_back(predict_map(px));
          default: ;
        endcase
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_OUT_MIN: level_min = cfg_data_i;
          REG_OUT_MAX: level_max = cfg_data_i;
          default: ;
        endcase
      end
      pending_o = stretched_q.size();
    end
  end

endmodule

### dv/testbench.sv
// Stimulus, clocking and verdict for the contrast stretch core testbench.
`timescale 1ns / 1ps

module testbench;
  import pccs_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 10;
  localparam int MAX_IDLE        = 5;
  // Settle time added after the last expected result word is back.
  localparam int SETTLE_CYCLES   = 40;
  localparam int LONG_HOLD       = 300;
  localparam int ITEM_TARGET     = 430;
  localparam int FRAMES_PER_SET  = 4;
  localparam int TIMEOUT_NS      = 2_000_000;

  // Command code 3 has no meaning; the core must drop such words untouched.
  localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

  typedef enum int {SPREAD_FLAT, SPREAD_NARROW, SPREAD_WIDE} spread_e;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [CMD_BITS-1:0]     cmd_i;
  logic [LEVEL_BITS-1:0]   red_i;
  logic [LEVEL_BITS-1:0]   green_i;
  logic [LEVEL_BITS-1:0]   blue_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [LEVEL_BITS-1:0]   red_out_o;
  logic [LEVEL_BITS-1:0]   green_out_o;
  logic [LEVEL_BITS-1:0]   blue_out_o;
  logic [NUM_CHAN-1:0]     flat_mask_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i;
  logic [LEVEL_BITS-1:0]   cfg_data_i;

  int mismatch_count;
  int pending_words;
  int words_sent = 0;

  // Idle switches; cleared now and then to get back-to-back stretches.
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  // Set by the stimulus to start a long receiver hold-off; the receiver clears it.
  bit long_hold_req = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  per_channel_contrast_stretch_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .flat_mask_o (flat_mask_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  contrast_stretch_checker checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .cmd_i            (cmd_i),
    .red_i            (red_i),
    .green_i          (green_i),
    .blue_i           (blue_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .red_out_i        (red_out_o),
    .green_out_i      (green_out_o),
    .blue_out_i       (blue_out_o),
    .flat_mask_i      (flat_mask_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_words)
  );

  // Any component value, weighted toward the two ends of the range.
  function automatic logic [LEVEL_BITS-1:0] any_comp();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return LEVEL_MAX;
      default: return LEVEL_BITS'($urandom_range(0, 255));
    endcase
  endfunction

  // Measured values per channel: a constant channel ends up flat, a narrow one
  // gives small divisors with large extrapolation, a wide one the normal case.
  function automatic logic [LEVEL_BITS-1:0] spread_comp(input spread_e mode,
                                                        input logic [LEVEL_BITS-1:0] base);
    case (mode)
      SPREAD_FLAT:   return base;
      SPREAD_NARROW: return base ^ LEVEL_BITS'($urandom_range(0, 3));
      default:       return any_comp();
    endcase
  endfunction

  // Receiver. The stall decision is made at each falling edge from a hold
  // counter that is redrawn after every accepted result word, so stalls can
  // land on any cycle of the core's work. A long hold request overrides it.
  initial begin
    bit took;
    int rx_hold;
    rx_hold = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      took = out_valid_o && !out_stall_i;
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rx_hold = LONG_HOLD;
      end else if (took) begin
        rx_hold = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (rx_hold > 0) begin
        out_stall_i = 1'b1;
        rx_hold--;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  // Offers one word, after a random gap while tx_idle is set, and returns at the falling
  // edge after it was taken, with valid still high so a following word can go back to back.
  task automatic send_word(input logic [CMD_BITS-1:0] cmd, input logic [LEVEL_BITS-1:0] r,
                           input logic [LEVEL_BITS-1:0] g, input logic [LEVEL_BITS-1:0] b);
    int gap;
    gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    cmd_i      = cmd;
    red_i      = r;
    green_i    = g;
    blue_i     = b;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    if (cmd != CMD_UNUSED) words_sent++;
  endtask

  // Stops offering words and waits until every expected result word is back.
  // The extra cycles let a trailing clear or measure word settle in the core.
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (pending_words != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Writes both level registers back to back; only called with the core idle.
  task automatic set_levels(input logic [LEVEL_BITS-1:0] lo, input logic [LEVEL_BITS-1:0] hi);
    cfg_valid_i = 1'b1;
    cfg_index_i = REG_OUT_MIN;
    cfg_data_i  = lo;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_index_i = REG_OUT_MAX;
    cfg_data_i  = hi;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // One image frame: usually a clear, a measure pass and a map pass. Now and
  // then the clear is skipped so statistics carry over, and stray unknown
  // commands or early maps are mixed into the measure pass.
  task automatic run_frame();
    spread_e               mode [NUM_CHAN];
    logic [LEVEL_BITS-1:0] base [NUM_CHAN];
    logic [LEVEL_BITS-1:0] px   [NUM_CHAN];
    int                    n_measure;
    int                    n_map;
    tx_idle = ($urandom_range(0, 3) != 0);
    rx_idle = ($urandom_range(0, 3) != 0);
    for (int c = 0; c < NUM_CHAN; c++) begin
      mode[c] = spread_e'($urandom_range(0, 3) > 1 ? SPREAD_WIDE : $urandom_range(0, 1));
      base[c] = any_comp();
    end
    if ($urandom_range(0, 5) != 0) send_word(CMD_CLEAR, any_comp(), any_comp(), any_comp());
    n_measure = $urandom_range(1, 8);
    repeat (n_measure) begin
      for (int c = 0; c < NUM_CHAN; c++) px[c] = spread_comp(mode[c], base[c]);
      send_word(CMD_MEASURE, px[0], px[1], px[2]);
      case ($urandom_range(0, 11))
        0: send_word(CMD_UNUSED, any_comp(), any_comp(), any_comp());
        1: send_word(CMD_MAP, any_comp(), any_comp(), any_comp());
        default: ;
      endcase
    end
    n_map = $urandom_range(1, 8);
    repeat (n_map) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        px[c] = ($urandom_range(0, 1) != 0) ? spread_comp(mode[c], base[c]) : any_comp();
      end
      send_word(CMD_MAP, px[0], px[1], px[2]);
    end
  endtask

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int phase;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    cmd_i       = CMD_CLEAR;
    red_i       = '0;
    green_i     = '0;
    blue_i      = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_OUT_MIN;
    cfg_data_i  = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part, default levels 0 and 255 first. A map before any measure
    // sees minimum 255 and maximum 0, so the divisor is negative.
    send_word(CMD_MAP, 8'd0, 8'd128, 8'd255);
    // An unknown command must leave the statistics alone; the next map
    // would differ if it were taken as a measure.
    send_word(CMD_UNUSED, 8'd0, 8'd0, 8'd0);
    send_word(CMD_MAP, 8'd255, 8'd255, 8'd255);
    // A single measured pixel makes every channel flat.
    send_word(CMD_MEASURE, 8'd10, 8'd200, 8'd77);
    send_word(CMD_MAP, 8'd10, 8'd200, 8'd77);
    // Widen red and green only; map values outside the measured range so the
    // ramp extrapolates past both ends and gets clamped. Blue stays flat.
    send_word(CMD_MEASURE, 8'd250, 8'd0, 8'd77);
    send_word(CMD_MAP, 8'd0, 8'd255, 8'd77);
    send_word(CMD_MAP, 8'd130, 8'd100, 8'd77);
    // Full range statistics after a clear.
    send_word(CMD_CLEAR, 8'd255, 8'd255, 8'd255);
    send_word(CMD_MEASURE, 8'd0, 8'd0, 8'd0);
    send_word(CMD_MEASURE, 8'd255, 8'd255, 8'd255);
    send_word(CMD_MAP, 8'd0, 8'd255, 8'd128);
    send_word(CMD_MAP, 8'd255, 8'd0, 8'd1);
    // Inverted ramp with out_min above out_max.
    drain_results();
    set_levels(8'd200, 8'd20);
    send_word(CMD_MAP, 8'd0, 8'd128, 8'd255);
    send_word(CMD_MAP, 8'd64, 8'd32, 8'd16);
    // Both levels at full scale, then the steepest inverted ramp.
    drain_results();
    set_levels(8'd255, 8'd255);
    send_word(CMD_MAP, 8'd0, 8'd255, 8'd7);
    drain_results();
    set_levels(8'd255, 8'd0);
    send_word(CMD_MAP, 8'd0, 8'd255, 8'd100);

    // Random part. Each phase drains the core, picks new levels and runs a few
    // frames. The fixed settings cover the extremes; the rest are random.
    phase = 0;
    while (words_sent < ITEM_TARGET) begin
      drain_results();
      case (phase % 6)
        0: set_levels(8'd0, 8'd255);
        1: set_levels(8'd255, 8'd0);
        2: set_levels(8'd0, 8'd0);
        3: set_levels(8'd255, 8'd255);
        default: set_levels(LEVEL_BITS'($urandom_range(0, 255)),
                            LEVEL_BITS'($urandom_range(0, 255)));
      endcase
      if (phase == 3) begin
        // Receiver holds off while map words keep coming without gaps, so the
        // output register fills and the core has to stall its input.
        long_hold_req = 1'b1;
        tx_idle = 1'b0;
        repeat (10) send_word(CMD_MAP, any_comp(), any_comp(), any_comp());
      end
      repeat (FRAMES_PER_SET) run_frame();
      phase++;
    end

    drain_results();
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### per_channel_contrast_stretch_core.f
+incdir+rtl
rtl/pccs_pkg.sv
rtl/pccs_lane.sv
rtl/per_channel_contrast_stretch_core.sv
dv/contrast_stretch_checker.sv
dv/testbench.sv
